// ----- src/ffca_pkg.sv -----
// shared types and constants for the first-fit contiguous allocator
`timescale 1ns / 1ps

package ffca_pkg;

    localparam int SIZE_W    = 11;
    localparam int ID_IN_W   = 10;
    localparam int VALUE_W   = 11;
    localparam int POOL_W    = 11;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    localparam logic [POOL_W-1:0] POOL_RESET = 11'd1024;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic start;
        logic vld;
        logic is_free;
    } t_scan_ctrl;

endpackage

// ----- src/ffca_ram.sv -----
// generic single write port memory with registered read
`timescale 1ns / 1ps

module ffca_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ffca_scan.sv -----
// shared scan unit: free run counter, run length compare and owner match count
`timescale 1ns / 1ps

module ffca_scan #(
    parameter int MAX_UNITS = 1024,
    parameter int ID_BITS   = 10,
    localparam int AW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1,
    localparam int CW = $clog2(MAX_UNITS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffca_pkg::t_scan_ctrl        i_ctrl,
    input  logic                        i_busy,
    input  logic [ID_BITS-1:0]          i_owner,
    input  logic [ID_BITS-1:0]          i_id,
    input  logic [ffca_pkg::SIZE_W-1:0] i_size,
    input  logic [AW-1:0]               i_addr,
    output logic                        o_hit,
    output logic                        o_match,
    output logic [CW-1:0]               o_start,
    output logic [CW-1:0]               o_count
);

    import ffca_pkg::*;

    localparam int PW = (CW > SIZE_W) ? CW : SIZE_W;

    logic [CW-1:0] r_run;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_run;
    logic [CW-1:0] n_cnt;

    assign o_hit = i_ctrl.vld && !i_ctrl.is_free && !i_busy
                   && ((PW'(r_run) + PW'(1)) == PW'(i_size));
    assign o_match = i_ctrl.vld && i_ctrl.is_free && i_busy && (i_owner == i_id);
    assign o_start = CW'(PW'(i_addr) + PW'(1) - PW'(i_size));

    always_comb begin
        n_run = r_run;
        n_cnt = r_cnt;
        if (i_ctrl.start) begin
            n_run = '0;
            n_cnt = '0;
        end else begin
            if (i_ctrl.vld && !i_ctrl.is_free) begin
                n_run = i_busy ? '0 : r_run + CW'(1);
            end
            if (o_match) begin
                n_cnt = r_cnt + CW'(1);
            end
        end
    end

    assign o_count = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
            r_cnt <= '0;
        end else begin
            r_run <= n_run;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- src/first_fit_contiguous_allocator_unit.sv -----
// First-fit contiguous allocator over a pool of up to MAX_UNITS units. An allocate item
// (tuser 0) claims the leftmost run of request_size free units for owner_id and returns
// its start with granted set; a free item (tuser 1) releases every unit of owner_id and
// returns the count. Unit state lives in one memory with one read and one write port,
// scanned one unit per cycle: an allocate is refused after a full scan of the pool, or
// granted when a run is found and then marked unit by unit; a free always scans all
// MAX_UNITS units; a zero or oversize request is refused with no scan. After reset a
// clearing pass over all MAX_UNITS units runs before the first item is accepted. The next
// item is taken while a result still waits in the output register.
`timescale 1ns / 1ps

module first_fit_contiguous_allocator_unit #(
    parameter int MAX_UNITS = 1024,
    parameter int ID_BITS   = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ffca_pkg::POOL_W-1:0]    i_cfg_wdata,  // pool_size
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ffca_pkg::S_TDATA_W-1:0] s_axis_tdata, // request_size, owner_id
    input  logic                           s_axis_tuser, // operation
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ffca_pkg::M_TDATA_W-1:0] m_axis_tdata, // value
    output logic                           m_axis_tuser  // granted
);

    import ffca_pkg::*;

    localparam int AW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int CW = $clog2(MAX_UNITS + 1);
    localparam int PW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int OW = (ID_BITS > ID_IN_W) ? ID_BITS : ID_IN_W;
    localparam int EW = ID_BITS + 1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_ALLOC = 6'b000100,
        S_MARK  = 6'b001000,
        S_FREE  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [POOL_W-1:0]    r_pool;
    logic                 r_op;
    logic [SIZE_W-1:0]    r_size;
    logic [ID_BITS-1:0]   r_owner;
    logic [CW-1:0]        r_rd_cnt;
    logic                 r_rd_vld;
    logic                 r_rd_last;
    logic [AW-1:0]        r_proc_addr;
    logic [AW-1:0]        r_mark;
    logic [AW-1:0]        r_end;
    logic [AW-1:0]        r_clr;
    logic                 r_res_granted;
    logic [VALUE_W-1:0]   r_res_value;
    logic                 r_out_valid;
    logic                 r_out_granted;
    logic [VALUE_W-1:0]   r_out_value;

    logic [SIZE_W-1:0]    w_size;
    logic [OW-1:0]        w_owner_ext;
    logic [ID_BITS-1:0]   w_owner;
    logic [PW-1:0]        w_pool;
    logic [PW-1:0]        w_limit;
    logic                 w_scan;
    logic                 w_issue;
    logic                 w_accept;
    logic                 w_refuse;
    logic                 w_load;
    t_scan_ctrl           w_ctrl;
    logic                 w_hit;
    logic                 w_match;
    logic [CW-1:0]        w_start;
    logic [CW-1:0]        w_count;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [EW-1:0]        w_wdata;
    logic [EW-1:0]        w_rdata;

    assign w_size      = s_axis_tdata[SIZE_W-1:0];
    assign w_owner_ext = OW'(s_axis_tdata[SIZE_W +: ID_IN_W]);
    assign w_owner     = w_owner_ext[ID_BITS-1:0];

    assign w_pool  = (PW'(r_pool) > PW'(MAX_UNITS)) ? PW'(MAX_UNITS) : PW'(r_pool);
    assign w_limit = (r_op == OP_FREE) ? PW'(MAX_UNITS) : w_pool;

    assign w_scan   = (r_state == S_ALLOC) || (r_state == S_FREE);
    assign w_issue  = w_scan && (PW'(r_rd_cnt) < w_limit);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_refuse = (w_size == '0) || (PW'(w_size) > w_pool);
    assign w_load   = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    assign w_ctrl.start   = w_accept;
    assign w_ctrl.vld     = r_rd_vld && w_scan;
    assign w_ctrl.is_free = (r_op == OP_FREE);

    ffca_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_UNITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (r_rd_cnt[AW-1:0]),
        .o_rdata (w_rdata)
    );

    ffca_scan #(
        .MAX_UNITS (MAX_UNITS),
        .ID_BITS   (ID_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_busy  (w_rdata[ID_BITS]),
        .i_owner (w_rdata[ID_BITS-1:0]),
        .i_id    (r_owner),
        .i_size  (r_size),
        .i_addr  (r_proc_addr),
        .o_hit   (w_hit),
        .o_match (w_match),
        .o_start (w_start),
        .o_count (w_count)
    );

    // memory write port and next state
    always_comb begin
        n_state = r_state;
        w_we    = 1'b0;
        w_waddr = r_proc_addr;
        w_wdata = {1'b0, w_rdata[ID_BITS-1:0]};
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                if (r_clr == AW'(MAX_UNITS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == OP_FREE) begin
                        n_state = S_FREE;
                    end else if (w_refuse) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end
            end
            S_ALLOC: begin
                if (w_hit) begin
                    n_state = S_MARK;
                end else if (w_ctrl.vld && r_rd_last) begin
                    n_state = S_DONE;
                end
            end
            S_MARK: begin
                w_we    = 1'b1;
                w_waddr = r_mark;
                w_wdata = {1'b1, r_owner};
                if (r_mark == r_end) begin
                    n_state = S_DONE;
                end
            end
            S_FREE: begin
                w_we = w_match;
                if (w_ctrl.vld && r_rd_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pool      <= POOL_RESET;
            r_clr       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;
            if (i_cfg_we) begin
                r_pool <= i_cfg_wdata;
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload and scan datapath
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_cnt    <= r_rd_cnt + CW'(1);
            r_proc_addr <= r_rd_cnt[AW-1:0];
            r_rd_last   <= ((PW'(r_rd_cnt) + PW'(1)) == w_limit);
        end
        if (w_accept) begin
            r_op          <= s_axis_tuser;
            r_size        <= w_size;
            r_owner       <= w_owner;
            r_rd_cnt      <= '0;
            r_res_granted <= 1'b0;
            r_res_value   <= '0;
        end
        if ((r_state == S_ALLOC) && w_hit) begin
            r_mark        <= w_start[AW-1:0];
            r_end         <= r_proc_addr;
            r_res_granted <= 1'b1;
            r_res_value   <= VALUE_W'(w_start);
        end
        if (r_state == S_MARK) begin
            r_mark <= r_mark + AW'(1);
        end
        if ((r_state == S_FREE) && w_ctrl.vld && r_rd_last) begin
            r_res_granted <= 1'b1;
            r_res_value   <= VALUE_W'(w_count);
        end
        if (w_load) begin
            r_out_granted <= r_res_granted;
            r_out_value   <= r_res_value;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_value);
    assign m_axis_tuser  = r_out_granted;

endmodule

// ----- src/ffca_checker.sv -----
// port-level checks for the first-fit contiguous allocator
`timescale 1ns / 1ps

module ffca_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [ffca_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ffca_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser
);

    import ffca_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while previous one in work");

    // refused allocation reports zero
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("refused result with nonzero value");

    // reset starts the clearing pass with no result pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("block active right after reset");

endmodule

bind first_fit_contiguous_allocator_unit ffca_checker u_ffca_checker (.*);
